// ===== rtl/tfb_pkg.sv =====
package tfb_pkg;

  localparam int MAX_VALUES = 23;
  localparam int COUNT_W    = $clog2(MAX_VALUES + 1);

  localparam logic [7:0] SYNC_BYTE_0 = 8'hAA;
  localparam logic [7:0] SYNC_BYTE_1 = 8'hFF;

  localparam int SAMPLE_W = 32;
  localparam int SCALE_W  = 10;
  localparam int PROD_W   = SAMPLE_W + SCALE_W;
  localparam logic [SCALE_W-1:0] SCALE_FACTOR = SCALE_W'(1000);
  localparam int FRAC_W   = 16;

  localparam int HDR_BYTES  = 4;
  localparam int VAL_BYTES  = 4;
  localparam int BUF_BYTES  = HDR_BYTES + VAL_BYTES;
  localparam int DLEFT_W    = $clog2(BUF_BYTES + 1);
  localparam int TAIL_BYTES = 2;
  localparam int TLEFT_W    = $clog2(TAIL_BYTES + 1);

  typedef struct packed {
    logic [7:0]                 frame_id;
    logic [4:0]                 value_count;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // One accepted request after the frame counter has looked at it.
  typedef struct packed {
    logic                hdr;
    logic                last;
    logic [7:0]          frame_id;
    logic [7:0]          len;
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
  } front_item_t;

endpackage

// ===== rtl/tfb_front.sv =====
module tfb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  tfb_pkg::in_item_t    sample,
  output logic                 item_valid,
  output tfb_pkg::front_item_t item,
  input  logic                 take
);
  import tfb_pkg::*;

  logic [COUNT_W-1:0] values_left, values_left_next, cnt;
  logic               accept, hdr;
  front_item_t        item_next;

  assign sample_stall = item_valid && !take;
  assign accept       = sample_valid && !sample_stall;
  assign hdr          = (values_left == '0);

  always_comb begin
    if (sample.value_count == '0) begin
      cnt = COUNT_W'(1);
    end else if (int'(sample.value_count) > MAX_VALUES) begin
      cnt = COUNT_W'(MAX_VALUES);
    end else begin
      cnt = COUNT_W'(sample.value_count);
    end
    values_left_next = hdr ? (cnt - COUNT_W'(1)) : (values_left - COUNT_W'(1));

    item_next.hdr      = hdr;
    item_next.last     = (values_left_next == '0);
    item_next.frame_id = sample.frame_id;
    item_next.len      = 8'({cnt, 2'b00});
    item_next.neg      = sample.sample_value[SAMPLE_W-1];
    // The most negative input maps onto itself, which is its correct magnitude.
    item_next.mag      = item_next.neg ? (~sample.sample_value + SAMPLE_W'(1))
                                       : sample.sample_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid  <= 1'b0;
      values_left <= '0;
    end else begin
      if (accept) begin
        item_valid  <= 1'b1;
        values_left <= values_left_next;
      end else if (take) begin
        item_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

// ===== rtl/tfb_scale.sv =====
module tfb_scale (
  input  logic                         neg,
  input  logic [tfb_pkg::SAMPLE_W-1:0] mag,
  output logic [tfb_pkg::SAMPLE_W-1:0] scaled
);
  import tfb_pkg::*;

  logic [PROD_W-1:0]          prod;
  logic [PROD_W-FRAC_W-1:0]   q;
  logic [SAMPLE_W-1:0]        q_ext;

  // Scaling the magnitude truncates toward zero; the result stays well inside
  // the signed 32-bit range, so no saturation is ever needed.
  always_comb begin
    prod   = PROD_W'(mag) * PROD_W'(SCALE_FACTOR);
    q      = prod[PROD_W-1:FRAC_W];
    q_ext  = SAMPLE_W'(q);
    scaled = neg ? (~q_ext + SAMPLE_W'(1)) : q_ext;
  end

endmodule

// ===== rtl/tfb_serial.sv =====
module tfb_serial (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  tfb_pkg::front_item_t         item,
  input  logic [tfb_pkg::SAMPLE_W-1:0] scaled,
  output logic                         take,
  output logic                         octet_valid,
  input  logic                         octet_stall,
  output tfb_pkg::out_item_t           octet
);
  import tfb_pkg::*;

  logic [7:0]         shreg [BUF_BYTES];
  logic [DLEFT_W-1:0] data_left;
  logic [TLEFT_W-1:0] tail_left;
  logic [7:0]         sum_check, add_check, sum_next;
  logic               busy, fire, last_byte;

  assign busy      = (data_left != '0) || (tail_left != '0);
  assign fire      = busy && !octet_stall;
  assign last_byte = ((data_left == DLEFT_W'(1)) && (tail_left == '0)) ||
                     ((data_left == '0) && (tail_left == TLEFT_W'(1)));
  assign take      = item_valid && (!busy || (fire && last_byte));
  assign sum_next  = sum_check + shreg[0];

  assign octet_valid = busy;

  always_comb begin
    if (data_left != '0) begin
      octet.out_byte = shreg[0];
    end else if (tail_left == TLEFT_W'(TAIL_BYTES)) begin
      octet.out_byte = sum_check;
    end else begin
      octet.out_byte = add_check;
    end
    octet.run_last  = last_byte;
    octet.frame_end = (data_left == '0) && (tail_left == TLEFT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_left <= '0;
      tail_left <= '0;
    end else if (take) begin
      data_left <= item.hdr ? DLEFT_W'(BUF_BYTES) : DLEFT_W'(VAL_BYTES);
      tail_left <= item.last ? TLEFT_W'(TAIL_BYTES) : '0;
    end else if (fire) begin
      if (data_left != '0) begin
        data_left <= data_left - DLEFT_W'(1);
      end else begin
        tail_left <= tail_left - TLEFT_W'(1);
      end
    end
  end

  // Only header and payload bytes fold into the checks; a new frame clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_check <= '0;
      add_check <= '0;
    end else if (take && item.hdr) begin
      sum_check <= '0;
      add_check <= '0;
    end else if (fire && (data_left != '0)) begin
      sum_check <= sum_next;
      add_check <= add_check + sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (item.hdr) begin
        shreg[0] <= SYNC_BYTE_0;
        shreg[1] <= SYNC_BYTE_1;
        shreg[2] <= item.frame_id;
        shreg[3] <= item.len;
        for (int i = 0; i < VAL_BYTES; i++) begin
          shreg[HDR_BYTES + i] <= scaled[8*i +: 8];
        end
      end else begin
        for (int i = 0; i < VAL_BYTES; i++) begin
          shreg[i] <= scaled[8*i +: 8];
        end
      end
    end else if (fire && (data_left != '0)) begin
      for (int i = 0; i < BUF_BYTES - 1; i++) begin
        shreg[i] <= shreg[i + 1];
      end
    end
  end

endmodule

// ===== rtl/telemetry_frame_builder.sv =====
// Telemetry frame builder. Each request carries one signed Q16.16 sample; the
// first request of a frame also supplies the frame id and the value count
// (0 is taken as 1, counts above the maximum are clamped). Output is a byte
// stream: 0xAA, 0xFF, id and length on the first value, four little-endian
// bytes of the sample times 1000 (truncated toward zero) for every value, and
// the sum check and add check after the last value. One request produces 4, 8,
// 6 or 10 bytes, and the byte shift register moves out one byte per cycle
// when the receiver does not stall. An input register holds the next request
// while the current one shifts out and hands it to the shift register in the
// cycle the last byte of the current one goes out, so bytes flow without gaps
// when the next request is already waiting. The 32 by 10 bit scaling multiply
// sits between the input register and the shift register.
module telemetry_frame_builder (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  tfb_pkg::in_item_t  sample,
  output logic               octet_valid,
  input  logic               octet_stall,
  output tfb_pkg::out_item_t octet
);
  import tfb_pkg::*;

  logic                item_valid, take;
  front_item_t         item;
  logic [SAMPLE_W-1:0] scaled;

  tfb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .item_valid   (item_valid),
    .item         (item),
    .take         (take)
  );

  tfb_scale u_scale (
    .neg    (item.neg),
    .mag    (item.mag),
    .scaled (scaled)
  );

  tfb_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .scaled      (scaled),
    .take        (take),
    .octet_valid (octet_valid),
    .octet_stall (octet_stall),
    .octet       (octet)
  );

endmodule

// ===== rtl/tfb_checker.sv =====
module tfb_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input tfb_pkg::in_item_t  sample,
  input logic               octet_valid,
  input logic               octet_stall,
  input tfb_pkg::out_item_t octet
);
  import tfb_pkg::*;

  // The output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !octet_valid)
    else $error("output valid right after reset");

  // A stalled request holds until it is taken.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled request changed");

  // A stalled byte holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    octet_valid && octet_stall |=> octet_valid && $stable(octet))
    else $error("stalled byte changed");

  // The closing add check is always the last byte of its request.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    octet_valid && octet.frame_end |-> octet.run_last)
    else $error("frame end without run last");

  // The bytes of one request leave without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    octet_valid && !octet_stall && !octet.run_last |=> octet_valid)
    else $error("gap inside the bytes of one request");

endmodule

bind telemetry_frame_builder tfb_checker u_tfb_checker (.*);
